// ===== hw/rtl/tlh_pkg.sv =====
// ----------------------------------------------------------------------------
// tlh_pkg
// shared widths, register indexes and queue entry type of the line height core
// ----------------------------------------------------------------------------
`default_nettype none
package tlh_pkg;
  localparam int CNT_W      = 13;
  localparam int VOTE_W     = 12;
  localparam int BIN_W      = 9;
  localparam int DEF_MAX_DIM   = 4096;
  localparam int DEF_HIST_BINS = 512;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

  localparam logic [2:0] REG_DARK_THR  = 3'd0;
  localparam logic [2:0] REG_DENSITY   = 3'd1;
  localparam logic [2:0] REG_MAX_GAP   = 3'd2;
  localparam logic [2:0] REG_MIN_LINE  = 3'd3;
  localparam logic [2:0] REG_BIN_WIDTH = 3'd4;

  // row summary handed from front to back
  typedef struct packed {
    logic             is_vote;   // a finished line votes
    logic             is_frame;  // frame end: report and clear
    logic [CNT_W-1:0] run;       // line height in rows
  } row_evt_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tlh_front.sv =====
// ----------------------------------------------------------------------------
// tlh_front
// per-row pixel counting, text row decision and run/gap tracking
// ----------------------------------------------------------------------------
`default_nettype none
module tlh_front import tlh_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic [7:0]       pixel,
  input  wire logic             in_region,
  input  wire logic             row_end,
  input  wire logic             frame_end,
  input  wire logic [7:0]       dark_thr,
  input  wire logic [7:0]       density,
  input  wire logic [7:0]       max_gap,
  input  wire logic [11:0]      min_line,
  output row_evt_t              evt,
  output logic                  evt_valid
);
  logic [CNT_W-1:0] dark_r, region_r, run_r, gap_r;
  logic [CNT_W-1:0] dark_nxt, region_nxt, run_nxt, gap_nxt;
  logic [CNT_W+7:0] prod;
  logic [CNT_W:0]   run_sum;
  logic [CNT_W-1:0] run_inc, gap_inc;
  logic             text, fin;

  always_comb begin
    dark_nxt   = dark_r;
    region_nxt = region_r;
    run_nxt    = run_r;
    gap_nxt    = gap_r;
    evt        = '0;
    evt_valid  = 1'b0;
    fin        = row_end | frame_end;
    // pixel counting
    if (in_region) begin
      if (region_r != CNT_MAX) region_nxt = region_r + 1'b1;
      if (pixel < dark_thr && dark_r != CNT_MAX) dark_nxt = dark_r + 1'b1;
    end
    prod    = dark_nxt * density;
    text    = prod > {8'd0, region_nxt};
    run_inc = (run_r == CNT_MAX) ? CNT_MAX : run_r + 1'b1;
    gap_inc = (gap_r == CNT_MAX) ? CNT_MAX : gap_r + 1'b1;
    run_sum = {1'b0, run_inc} + {1'b0, gap_r};
    // row end: text or gap update
    if (in_fire && fin) begin
      dark_nxt   = '0;
      region_nxt = '0;
      if (text) begin
        run_nxt = run_inc;
        if (gap_r < {5'd0, max_gap})
          run_nxt = run_sum[CNT_W] ? CNT_MAX : run_sum[CNT_W-1:0];
        gap_nxt = '0;
      end else begin
        gap_nxt = gap_inc;
        if (gap_inc >= {5'd0, max_gap} && run_r != '0) begin
          evt.is_vote = run_r > {1'b0, min_line};
          evt.run     = run_r;
          run_nxt     = '0;
        end
      end
      if (frame_end) begin
        evt.is_frame = 1'b1;
        run_nxt = '0;
        gap_nxt = '0;
      end
      evt_valid = evt.is_vote | evt.is_frame;
    end else if (!in_fire) begin
      dark_nxt   = dark_r;
      region_nxt = region_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r <= '0; region_r <= '0; run_r <= '0; gap_r <= '0;
    end else begin
      dark_r <= dark_nxt; region_r <= region_nxt;
      run_r <= run_nxt; gap_r <= gap_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tlh_queue.sv =====
// ----------------------------------------------------------------------------
// tlh_queue
// small fifo of row events between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module tlh_queue import tlh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  row_evt_t      push_data,
  input  wire logic     pop,
  output row_evt_t      head,
  output logic          not_empty
);
  row_evt_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign head      = mem_r[rp_r];
  assign not_empty = cnt_r != 3'd0;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tlh_back.sv =====
// ----------------------------------------------------------------------------
// tlh_back
// vote binning by serial divide, histogram update, frame scan and clear
// ----------------------------------------------------------------------------
`default_nettype none
module tlh_back import tlh_pkg::*; #(
  parameter int HIST_BINS = DEF_HIST_BINS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  row_evt_t                q_head,
  output logic                    q_pop,
  input  wire logic [7:0]         bin_width,
  output logic                    idle,
  output logic                    out_valid,
  output logic [BIN_W-1:0]        dominant_bin,
  output logic [VOTE_W-1:0]       dominant_votes,
  output logic [VOTE_W-1:0]       lines_found,
  output logic                    no_lines
);
  localparam int AW = $clog2(HIST_BINS);
  localparam int QW = CNT_W + 1;
  localparam logic [AW-1:0] TOP = AW'(HIST_BINS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DIV = 6'b000010, S_RD = 6'b000100,
    S_WR = 6'b001000, S_SCAN = 6'b010000, S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [VOTE_W-1:0] hist_r [HIST_BINS];
  logic [VOTE_W-1:0] rd_r;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [8:0]    rem_r, rem_nxt;
  logic [QW-1:0] num_r, num_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [AW-1:0] addr_r, addr_nxt, best_bin_r, best_bin_nxt;
  logic [VOTE_W-1:0] best_r, best_nxt, total_r, total_nxt;
  logic          rd_en, wr_en, scan_last_r, scan_last_nxt;
  logic          frame_pend_r, frame_pend_nxt;
  logic [VOTE_W-1:0] wr_data;
  logic [8:0]    trial;

  assign idle = (state_r == S_IDLE) && !q_valid;

  always_comb begin
    state_nxt = state_r; quo_nxt = quo_r; rem_nxt = rem_r; num_nxt = num_r;
    step_nxt = step_r; addr_nxt = addr_r; best_nxt = best_r;
    best_bin_nxt = best_bin_r; total_nxt = total_r; scan_last_nxt = scan_last_r;
    frame_pend_nxt = frame_pend_r;
    q_pop = 1'b0; rd_en = 1'b0; wr_en = 1'b0; wr_data = '0;
    out_valid = 1'b0;
    trial = {rem_r[7:0], num_r[QW-1]};
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          frame_pend_nxt = q_head.is_frame;
          // a vote on the frame end row is cast before the scan
          if (q_head.is_vote) begin
            num_nxt = {q_head.run, 1'b0}; quo_nxt = '0; rem_nxt = '0;
            step_nxt = '0;
            state_nxt = S_DIV;
          end else if (q_head.is_frame) begin
            addr_nxt = '0; best_nxt = '0; best_bin_nxt = AW'(1);
            scan_last_nxt = 1'b0; frame_pend_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (bin_width == 8'd0) begin
          addr_nxt = TOP; state_nxt = S_RD;
        end else begin
          num_nxt = num_r << 1;
          if (trial >= {1'b0, bin_width}) begin
            rem_nxt = trial - {1'b0, bin_width}; quo_nxt = {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_nxt = trial; quo_nxt = {quo_r[QW-2:0], 1'b0};
          end
          step_nxt = step_r + 1'b1;
          if (step_r == 4'(QW - 1)) begin
            addr_nxt = (quo_nxt > QW'(HIST_BINS - 1)) ? TOP : quo_nxt[AW-1:0];
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        rd_en = 1'b1; state_nxt = S_WR;
      end
      S_WR: begin
        wr_en = 1'b1;
        wr_data = (rd_r == VOTE_MAX) ? VOTE_MAX : rd_r + 1'b1;
        if (total_r != VOTE_MAX) total_nxt = total_r + 1'b1;
        if (frame_pend_r) begin
          addr_nxt = '0; best_nxt = '0; best_bin_nxt = AW'(1);
          scan_last_nxt = 1'b0; frame_pend_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // read each bin, compare the previous read, clear as we go
      S_SCAN: begin
        rd_en = 1'b1; wr_en = 1'b1; wr_data = '0;
        if (scan_last_r && rd_r > best_r) begin
          best_nxt = rd_r; best_bin_nxt = addr_r - 1'b1;
        end
        scan_last_nxt = 1'b1;
        if (addr_r == TOP) state_nxt = S_DONE;
        else addr_nxt = addr_r + 1'b1;
      end
      S_DONE: begin
        if (rd_r > best_r) begin
          best_nxt = rd_r; best_bin_nxt = addr_r;
        end
        out_valid = 1'b1;
        total_nxt = '0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign dominant_bin   = BIN_W'(best_bin_nxt);
  assign dominant_votes = best_nxt;
  assign lines_found    = total_r;
  assign no_lines       = best_nxt == '0;

  // histogram memory
  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= hist_r[addr_r];
    if (wr_en) hist_r[addr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; total_r <= '0; frame_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; total_r <= total_nxt; frame_pend_r <= frame_pend_nxt;
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt; num_r <= num_nxt; step_r <= step_nxt;
    addr_r <= addr_nxt; best_r <= best_nxt; best_bin_r <= best_bin_nxt;
    scan_last_r <= scan_last_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/text_line_height_estimator_core.sv =====
// ----------------------------------------------------------------------------
// text_line_height_estimator_core
// estimates dominant text line height of a grayscale frame
// ----------------------------------------------------------------------------
// pixels enter in raster order on start/busy; a transaction is taken when
// start is high and busy is low. the front counts each row and tracks text
// runs as each pixel is taken; finished lines and the frame end go through a
// four-entry queue to the back, which bins a vote with a serial divider and
// updates the histogram memory. busy rises once two events wait in the queue,
// so sustained rate is one pixel per cycle as long as votes come no faster
// than the back can bin them. at frame end the back scans and clears all
// HIST_BINS entries, one per cycle, then shows the result with out_valid for
// one cycle; busy stays high through the scan. the receiver cannot stall.
// the histogram holds no reset clearing: after reset no vote has been written
// and a clearing pass runs with busy high. config writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
module text_line_height_estimator_core import tlh_pkg::*; #(
  parameter int HIST_BINS = DEF_HIST_BINS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_pixel,
  input  wire logic        in_in_region,
  input  wire logic        in_row_end,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  output logic [BIN_W-1:0] out_dominant_bin,
  output logic [VOTE_W-1:0] out_dominant_votes,
  output logic [VOTE_W-1:0] out_lines_found,
  output logic             out_no_lines,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  logic [7:0]  dark_thr_r, density_r, max_gap_r, bin_width_r;
  logic [11:0] min_line_r;
  logic        in_fire, evt_valid, q_valid, q_pop, back_idle;
  logic        init_r, frame_wait_r;
  row_evt_t    evt, q_head, push_data;
  logic [2:0]  qcnt_r;
  logic        push;

  // during init, a frame event drives a clearing scan
  assign push      = init_r | (evt_valid & in_fire);
  assign push_data = init_r ? row_evt_t'{is_vote: 1'b0, is_frame: 1'b1, run: '0} : evt;
  assign busy      = init_r | frame_wait_r | (qcnt_r >= 3'd2);
  assign in_fire   = start & ~busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_thr_r <= 8'd126; density_r <= 8'd13; max_gap_r <= 8'd3;
      min_line_r <= 12'd8; bin_width_r <= 8'd15;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DARK_THR:  dark_thr_r  <= cfg_data[7:0];
        REG_DENSITY:   density_r   <= cfg_data[7:0];
        REG_MAX_GAP:   max_gap_r   <= cfg_data[7:0];
        REG_MIN_LINE:  min_line_r  <= cfg_data;
        REG_BIN_WIDTH: bin_width_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // queue fill, init pass and frame hold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0; init_r <= 1'b1; frame_wait_r <= 1'b1;
    end else begin
      qcnt_r <= qcnt_r + {2'd0, push} - {2'd0, q_pop};
      init_r <= 1'b0;
      if (in_fire && in_frame_end) frame_wait_r <= 1'b1;
      else if (back_idle && !push && qcnt_r == '0 && !init_r) frame_wait_r <= 1'b0;
    end
  end

  tlh_front u_front (
    .clk, .rst_n, .in_fire,
    .pixel(in_pixel), .in_region(in_in_region), .row_end(in_row_end),
    .frame_end(in_frame_end), .dark_thr(dark_thr_r), .density(density_r),
    .max_gap(max_gap_r), .min_line(min_line_r), .evt, .evt_valid
  );

  tlh_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop(q_pop), .head(q_head),
    .not_empty(q_valid)
  );

  logic back_out;
  tlh_back #(.HIST_BINS(HIST_BINS)) u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .bin_width(bin_width_r),
    .idle(back_idle), .out_valid(back_out),
    .dominant_bin(out_dominant_bin), .dominant_votes(out_dominant_votes),
    .lines_found(out_lines_found), .no_lines(out_no_lines)
  );

  // the clearing pass after reset reports nothing
  logic first_r;
  always_ff @(posedge clk) begin
    if (!rst_n) first_r <= 1'b1;
    else if (back_out) first_r <= 1'b0;
  end
  assign out_valid = back_out & ~first_r;
endmodule
`default_nettype wire

// ===== hw/rtl/tlh_checker.sv =====
// ----------------------------------------------------------------------------
// tlh_checker
// port level checks of the line height core
// ----------------------------------------------------------------------------
`default_nettype none
module tlh_checker import tlh_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_frame_end,
  input wire logic out_valid,
  input wire logic out_no_lines,
  input wire logic [VOTE_W-1:0] out_dominant_votes,
  input wire logic [VOTE_W-1:0] out_lines_found,
  input wire logic [BIN_W-1:0] out_dominant_bin
);
  // a frame end transaction blocks new pixels next cycle
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_frame_end |=> busy) else $error("no hold after frame end");
  // no_lines exactly when no votes
  a_nolines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_no_lines == (out_dominant_votes == '0)))
    else $error("no_lines mismatch");
  // empty result reports bin one
  a_defbin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_lines |-> out_dominant_bin == BIN_W'(1))
    else $error("default bin wrong");
  // dominant votes never exceed total
  a_votes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dominant_votes <= out_lines_found) else $error("votes exceed total");
  // result strobe is a single cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held");
endmodule

bind text_line_height_estimator_core tlh_checker u_tlh_checker (
  .clk, .rst_n, .start, .busy, .in_frame_end, .out_valid, .out_no_lines,
  .out_dominant_votes, .out_lines_found, .out_dominant_bin
);
`default_nettype wire

// ===== dv/text_line_height_estimator_core_tb.sv =====
// ----------------------------------------------------------------------------
// text_line_height_estimator_core_tb
// self-checking bench for the text line height estimator core
// ----------------------------------------------------------------------------
// raster frames built from text runs, blank gaps and noise rows are fed
// through the start/busy port. an in-bench line height tracker predicts the
// frame report of every frame end, and each out_valid transaction is
// compared with the oldest pending report. register settings change only
// while the core is idle: after reset and between test phases.
// ----------------------------------------------------------------------------
`default_nettype none
module text_line_height_estimator_core_tb;
  import tlh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_N      = DEF_HIST_BINS;
  localparam int SAT_CNT     = 8191;
  localparam int SAT_VOTE    = 4095;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = DEF_HIST_BINS + 40;

  typedef struct {
    logic [BIN_W-1:0]  bin;
    logic [VOTE_W-1:0] votes;
    logic [VOTE_W-1:0] lines;
    logic              none;
  } frame_report_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [7:0]        in_pixel;
  logic              in_in_region;
  logic              in_row_end;
  logic              in_frame_end;
  logic              out_valid;
  logic [BIN_W-1:0]  out_dominant_bin;
  logic [VOTE_W-1:0] out_dominant_votes;
  logic [VOTE_W-1:0] out_lines_found;
  logic              out_no_lines;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [11:0]       cfg_data;

  text_line_height_estimator_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_pixel           (in_pixel),
    .in_in_region       (in_in_region),
    .in_row_end         (in_row_end),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_dominant_bin   (out_dominant_bin),
    .out_dominant_votes (out_dominant_votes),
    .out_lines_found    (out_lines_found),
    .out_no_lines       (out_no_lines),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // tracker copy of the registers and frame state
  int dark_thr, density_div, gap_limit, min_rows, bin_halves;
  int dark_cnt, region_cnt, run_len, gap_len, line_cnt;
  int height_votes [HIST_N];

  frame_report_t pending_reports[$];
  int n_pixels, n_reports, n_errors, n_frames_sent, quiet_cycles;
  int idle_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int sat_inc(int v, int lim);
    return (v < lim) ? v + 1 : lim;
  endfunction

  function automatic void clear_frame_state();
    dark_cnt   = 0;
    region_cnt = 0;
    run_len    = 0;
    gap_len    = 0;
    line_cnt   = 0;
    foreach (height_votes[i]) height_votes[i] = 0;
  endfunction

  function automatic void record_line();
    int bin;
    if (bin_halves == 0) bin = HIST_N - 1;
    else bin = (run_len * 2) / bin_halves;
    if (bin > HIST_N - 1) bin = HIST_N - 1;
    height_votes[bin] = sat_inc(height_votes[bin], SAT_VOTE);
    line_cnt = sat_inc(line_cnt, SAT_VOTE);
  endfunction

  // row end: extend, absorb gap, or close the current text run
  function automatic void close_row();
    if (dark_cnt * density_div > region_cnt) begin
      run_len = sat_inc(run_len, SAT_CNT);
      if (gap_len < gap_limit) begin
        run_len = run_len + gap_len;
        if (run_len > SAT_CNT) run_len = SAT_CNT;
      end
      gap_len = 0;
    end else begin
      gap_len = sat_inc(gap_len, SAT_CNT);
      if (gap_len >= gap_limit && run_len != 0) begin
        if (run_len > min_rows) record_line();
        run_len = 0;
      end
    end
    dark_cnt   = 0;
    region_cnt = 0;
  endfunction

  function automatic void track_pixel(logic [7:0] p, logic r, logic re, logic fe);
    frame_report_t rep;
    int best_bin, best_votes;
    if (r) begin
      region_cnt = sat_inc(region_cnt, SAT_CNT);
      if (int'(p) < dark_thr) dark_cnt = sat_inc(dark_cnt, SAT_CNT);
    end
    if (re || fe) close_row();
    if (fe) begin
      best_bin   = 1;
      best_votes = 0;
      for (int b = 0; b < HIST_N; b++) begin
        if (height_votes[b] > best_votes) begin
          best_votes = height_votes[b];
          best_bin   = b;
        end
      end
      rep.bin   = best_bin[BIN_W-1:0];
      rep.votes = best_votes[VOTE_W-1:0];
      rep.lines = line_cnt[VOTE_W-1:0];
      rep.none  = (best_votes == 0);
      pending_reports = {pending_reports, rep};
      clear_frame_state();
    end
  endfunction

  // accepted pixel transactions feed the tracker; watchdog on quiet cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (start && !busy) begin
        n_pixels <= n_pixels + 1;
        track_pixel(in_pixel, in_in_region, in_row_end, in_frame_end);
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // report checker
  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_valid) begin
      n_reports <= n_reports + 1;
      if (pending_reports.size() == 0) begin
        $error("unexpected report: bin %0d votes %0d lines %0d none %0d",
               out_dominant_bin, out_dominant_votes, out_lines_found, out_no_lines);
        n_errors = n_errors + 1;
      end else begin
        want = pending_reports.pop_front();
        if (out_dominant_bin !== want.bin) begin
          $error("dominant_bin: expected %0d, got %0d", want.bin, out_dominant_bin);
          n_errors = n_errors + 1;
        end
        if (out_dominant_votes !== want.votes) begin
          $error("dominant_votes: expected %0d, got %0d", want.votes, out_dominant_votes);
          n_errors = n_errors + 1;
        end
        if (out_lines_found !== want.lines) begin
          $error("lines_found: expected %0d, got %0d", want.lines, out_lines_found);
          n_errors = n_errors + 1;
        end
        if (out_no_lines !== want.none) begin
          $error("no_lines: expected %0d, got %0d", want.none, out_no_lines);
          n_errors = n_errors + 1;
        end
      end
    end
  end

  // one pixel transaction, with a random idle gap before it
  task automatic send_pixel(logic [7:0] p, logic r, logic re, logic fe);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start        <= 1'b1;
    in_pixel     <= p;
    in_in_region <= r;
    in_row_end   <= re;
    in_frame_end <= fe;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    start     <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[11:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DARK_THR:  dark_thr    = value & 8'hFF;
      REG_DENSITY:   density_div = value & 8'hFF;
      REG_MAX_GAP:   gap_limit   = value & 8'hFF;
      REG_MIN_LINE:  min_rows    = value & 12'hFFF;
      REG_BIN_WIDTH: bin_halves  = value & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic write_all(int thr, int dv, int gp, int mn, int bw);
    write_reg(REG_DARK_THR, thr);
    write_reg(REG_DENSITY, dv);
    write_reg(REG_MAX_GAP, gp);
    write_reg(REG_MIN_LINE, mn);
    write_reg(REG_BIN_WIDTH, bw);
  endtask

  // wait for every report, then let the histogram scan finish
  task automatic drain();
    start <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one row: kind 0 blank, 1 text, 2 noise
  task automatic send_row(int kind, int width, bit last);
    logic [7:0] p;
    logic r, re;
    for (int c = 0; c < width; c++) begin
      re = (c == width - 1);
      case (kind)
        1: begin
          r = 1'b1;
          p = (dark_thr == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, dark_thr - 1));
        end
        0: begin
          r = 1'($urandom_range(0, 1));
          p = 8'($urandom_range(dark_thr, 255));
        end
        default: begin
          r = 1'($urandom_range(0, 1));
          p = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 9) == 0) re = 1'b1;
        end
      endcase
      send_pixel(p, r, re, last && (c == width - 1));
    end
  endtask

  // a frame of text runs and gaps, some rows replaced by noise
  task automatic send_frame(int width, int rows, int noise_pct);
    int done_rows, seg, kind;
    bit is_text;
    done_rows = 0;
    is_text   = 1'b1;
    while (done_rows < rows) begin
      seg = is_text ? $urandom_range(1, 14) : $urandom_range(0, 6);
      for (int k = 0; k < seg && done_rows < rows; k++) begin
        kind = ($urandom_range(0, 99) < noise_pct) ? 2 : int'(is_text);
        send_row(kind, width, 1'b0);
        done_rows++;
      end
      is_text = !is_text;
    end
    // frame end sometimes on its own pixel without row end, else on a last row
    if ($urandom_range(0, 9) == 0)
      send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
    else
      send_row($urandom_range(0, 1), width, 1'b1);
    n_frames_sent++;
  endtask

  // directed: default settings, field extremes, empty frames
  task automatic test_basic();
    idle_pct = 0;
    for (int i = 0; i < 10; i++) send_pixel(8'd0, 1'b1, 1'b1, 1'b0);
    send_pixel(8'd125, 1'b1, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd126, 1'b1, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b1, 1'b0);
    send_pixel(8'd200, 1'b0, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b1, 1'b1, 1'b1);
    send_pixel(8'd255, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd0, 1'b1, 1'b0, 1'b1);
    drain();
  endtask

  // register extremes including zero density and zero bin width
  task automatic test_reg_extremes();
    int cfgs [7][5] = '{
      '{0, 1, 1, 0, 1}, '{255, 255, 255, 4095, 255}, '{255, 0, 2, 0, 3},
      '{200, 13, 1, 0, 0}, '{128, 1, 2, 1, 1}, '{255, 255, 1, 0, 255},
      '{180, 20, 4, 2, 7}};
    idle_pct = 10;
    foreach (cfgs[i]) begin
      write_all(cfgs[i][0], cfgs[i][1], cfgs[i][2], cfgs[i][3], cfgs[i][4]);
      repeat (2) send_frame($urandom_range(1, 2), $urandom_range(10, 40), 10);
      drain();
    end
  endtask

  // a long row and a tall run push the bin index past the top bin
  task automatic test_saturation();
    idle_pct = 0;
    write_all(126, 13, 3, 8, 1);
    for (int i = 0; i < 120; i++) send_pixel(8'd0, 1'b1, i == 119, 1'b0);
    for (int i = 0; i < 300; i++) send_pixel(8'd3, 1'b1, 1'b1, 1'b0);
    for (int i = 0; i < 3; i++) send_pixel(8'd250, 1'b1, 1'b1, 1'b0);
    send_pixel(8'd250, 1'b1, 1'b1, 1'b1);
    drain();
  endtask

  // random frames under one sender idle rate
  task automatic test_random_frames(int pct, int pixel_goal, int frame_goal);
    int px0, fr0;
    idle_pct = pct;
    px0 = n_pixels;
    fr0 = n_frames_sent;
    write_all($urandom_range(60, 220), $urandom_range(1, 30), $urandom_range(1, 6),
              $urandom_range(0, 12), $urandom_range(1, 40));
    while (n_pixels - px0 < pixel_goal || n_frames_sent - fr0 < frame_goal)
      send_frame($urandom_range(1, 3), $urandom_range(8, 45), 15);
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_pixel     = '0;
    in_in_region = 1'b0;
    in_row_end   = 1'b0;
    in_frame_end = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    n_pixels = 0; n_reports = 0; n_errors = 0; n_frames_sent = 0; quiet_cycles = 0;
    idle_pct = 0;
    dark_thr = 126; density_div = 13; gap_limit = 3; min_rows = 8; bin_halves = 15;
    clear_frame_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_basic();
    test_reg_extremes();
    test_saturation();
    test_random_frames(0, 200, 4);
    test_random_frames(79, 200, 4);
    test_random_frames(24, 200, 4);

    $display("covered %0d pixels in %0d frames, %0d reports checked",
             n_pixels, n_frames_sent, n_reports);
    $display("register extremes, top bin clamping and three sender idle rates");
    if (n_errors == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
